// File: rtl/wsf_pkg.sv
// shared constants, types and weight tables for the 3x3 stencil filter
package wsf_pkg;

    // defaults for the top-level parameters
    localparam int DEFAULT_MAX_SIZE   = 1024;
    localparam int DEFAULT_COLOR_BITS = 16;

    // fixed port widths
    localparam int COLOR_PORT_BITS = 16;
    localparam int COORD_OUT_BITS  = 10;
    localparam int CFG_BITS        = 11;

    // image size after reset
    localparam int RESET_IMAGE_SIZE = 64;

    // window geometry and color planes
    localparam int WIN_DIM    = 3;
    localparam int NUM_COLORS = 3;

    // floor(x / 100) as (x * DIV_RECIP) >> DIV_SHIFT, exact for x below 2^22
    localparam int          DIV_SHIFT = 29;
    localparam int unsigned DIV_RECIP = 5368710;

    // tap weights in hundredths, [window row][window column]
    localparam int unsigned TAP_WEIGHT [WIN_DIM][WIN_DIM] = '{
        '{60, 3, 0},
        '{3, 30, 3},
        '{0, 3, 10}
    };

    // per-tap coefficient for one window column, weight folded into the reciprocal
    function automatic logic [WIN_DIM-1:0][DIV_SHIFT-1:0] tap_col_coef(input int col);
        logic [WIN_DIM-1:0][DIV_SHIFT-1:0] coef;
        for (int i = 0; i < WIN_DIM; i++) begin
            coef[i] = DIV_SHIFT'(TAP_WEIGHT[i][col] * DIV_RECIP);
        end
        return coef;
    endfunction

    // control bundle from the top level to each window cell
    typedef struct packed {
        logic               adv;     // pipeline moves this cycle
        logic               shift;   // a real word leaves the input stage
        logic               clear;   // frame restart
        logic [WIN_DIM-1:0] tap_en;  // taps of this column inside the image
    } cell_ctl_t;

endpackage

// File: rtl/weighted_3x3_stencil_filter.sv
// top level of the weighted 3x3 stencil filter with line buffers and window cells
//
//  channel   | ports                                   | word
//  ----------+-----------------------------------------+------------------------------
//  config    | cfg_valid cfg_ready cfg_image_size      | image width and height
//  pixel in  | s_valid s_ready s_red/green/blue_in     | one pixel, reverse raster
//  pixel out | m_valid m_ready m_red/green/blue_out,   | filtered pixel and position
//            | m_out_row m_out_col m_frame_end         |
//
//  one pixel per cycle while s_ready is high; a result passes from the line-buffer read
//  at the accepting edge through tap multiply, column sum and output register
//  aresetn is synchronous: size 64 (or the largest size if smaller), counters at
//  the last pixel, window cleared; a config word restarts the frame the same way
//  s_ready drops only while the skid register holds a word that m_ready refused
module weighted_3x3_stencil_filter #(
    parameter int MAX_SIZE   = wsf_pkg::DEFAULT_MAX_SIZE,
    parameter int COLOR_BITS = wsf_pkg::DEFAULT_COLOR_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wsf_pkg::CFG_BITS-1:0]        cfg_image_size,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [wsf_pkg::COLOR_PORT_BITS-1:0] s_red_in,
    input  logic [wsf_pkg::COLOR_PORT_BITS-1:0] s_green_in,
    input  logic [wsf_pkg::COLOR_PORT_BITS-1:0] s_blue_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [wsf_pkg::COLOR_PORT_BITS-1:0] m_red_out,
    output logic [wsf_pkg::COLOR_PORT_BITS-1:0] m_green_out,
    output logic [wsf_pkg::COLOR_PORT_BITS-1:0] m_blue_out,
    output logic [wsf_pkg::COORD_OUT_BITS-1:0]  m_out_row,
    output logic [wsf_pkg::COORD_OUT_BITS-1:0]  m_out_col,
    output logic                                m_frame_end
);

    localparam int COORD_BITS = $clog2(MAX_SIZE);
    localparam int SIZE_BITS  = $clog2(MAX_SIZE + 1);
    localparam int EXT_BITS   = SIZE_BITS + 1;
    localparam int CMP_BITS   = (SIZE_BITS > wsf_pkg::CFG_BITS) ? SIZE_BITS
                                                                : wsf_pkg::CFG_BITS;
    localparam int PIX_BITS   = wsf_pkg::NUM_COLORS * COLOR_BITS;
    localparam int RESET_SIZE = (wsf_pkg::RESET_IMAGE_SIZE > MAX_SIZE) ? MAX_SIZE
                                                                       : wsf_pkg::RESET_IMAGE_SIZE;
    localparam int WD         = wsf_pkg::WIN_DIM;
    localparam int NC         = wsf_pkg::NUM_COLORS;

    typedef logic [NC-1:0][COLOR_BITS-1:0] pix_t;
    typedef logic [WD-1:0][NC-1:0][COLOR_BITS-1:0] column_t;

    typedef struct packed {
        logic [wsf_pkg::COORD_OUT_BITS-1:0] row;
        logic [wsf_pkg::COORD_OUT_BITS-1:0] col;
        logic                               last;
    } meta_t;

    // handshakes
    logic cfg_fire;
    logic in_fire;
    logic adv;
    logic pipe_out;

    // frame size and position
    logic [SIZE_BITS-1:0]  size_reg;
    logic [SIZE_BITS-1:0]  size_next;
    logic [CMP_BITS-1:0]   cfg_ext;
    logic [COORD_BITS-1:0] size_m1;
    logic [COORD_BITS-1:0] new_m1;
    logic [COORD_BITS-1:0] row_cnt_reg;
    logic [COORD_BITS-1:0] col_cnt_reg;
    logic [WD-1:0]         row_ok;
    logic [WD-1:0]         col_ok;

    // input stage
    logic                  valid_a_reg;
    pix_t                  cur_a_reg;
    logic [COORD_BITS-1:0] col_a_reg;
    logic [WD-1:0]         row_ok_a_reg;
    logic [WD-1:0]         col_ok_a_reg;
    meta_t                 meta_a_reg;
    pix_t                  cur_in;

    // tap and sum stages
    logic  valid_b_reg;
    logic  valid_c_reg;
    meta_t meta_b_reg;
    meta_t meta_c_reg;

    // line buffers
    logic [PIX_BITS-1:0] rd_one;
    logic [PIX_BITS-1:0] rd_two;
    logic                lb_we;

    // window cells
    column_t            win_col [WD];
    wsf_pkg::cell_ctl_t cell_ctl [WD];
    pix_t               col_sum [WD];
    pix_t               fsum;

    // output register and skid
    logic  m_valid_reg;
    pix_t  out_pix_reg;
    meta_t out_meta_reg;
    logic  skid_valid_reg;
    pix_t  skid_pix_reg;
    meta_t skid_meta_reg;
    meta_t new_meta;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign adv       = ~skid_valid_reg;
    assign s_ready   = adv;
    assign in_fire   = s_valid & s_ready;
    assign pipe_out  = adv & valid_c_reg;

    // clamp the written size to 1..MAX_SIZE
    always_comb begin
        cfg_ext = CMP_BITS'(cfg_image_size);
        if (cfg_image_size == '0) begin
            size_next = SIZE_BITS'(1);
        end else if (cfg_ext > CMP_BITS'(MAX_SIZE)) begin
            size_next = SIZE_BITS'(MAX_SIZE);
        end else begin
            size_next = SIZE_BITS'(cfg_image_size);
        end
    end

    assign size_m1 = COORD_BITS'(size_reg - 1'b1);
    assign new_m1  = COORD_BITS'(size_next - 1'b1);

    // which window rows and columns lie inside the image
    always_comb begin
        for (int i = 0; i < WD; i++) begin
            row_ok[i] = (EXT_BITS'(row_cnt_reg) + EXT_BITS'(i)) < EXT_BITS'(size_reg);
            col_ok[i] = (EXT_BITS'(col_cnt_reg) + EXT_BITS'(i)) < EXT_BITS'(size_reg);
        end
    end

    assign cur_in[0] = s_red_in[COLOR_BITS-1:0];
    assign cur_in[1] = s_green_in[COLOR_BITS-1:0];
    assign cur_in[2] = s_blue_in[COLOR_BITS-1:0];

    // control state: size, position counters, stage valids, output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg       <= SIZE_BITS'(RESET_SIZE);
            row_cnt_reg    <= COORD_BITS'(RESET_SIZE - 1);
            col_cnt_reg    <= COORD_BITS'(RESET_SIZE - 1);
            valid_a_reg    <= 1'b0;
            valid_b_reg    <= 1'b0;
            valid_c_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_fire) begin
                size_reg    <= size_next;
                row_cnt_reg <= new_m1;
                col_cnt_reg <= new_m1;
            end else if (in_fire) begin
                if (col_cnt_reg == '0) begin
                    col_cnt_reg <= size_m1;
                    row_cnt_reg <= (row_cnt_reg == '0) ? size_m1 : row_cnt_reg - 1'b1;
                end else begin
                    col_cnt_reg <= col_cnt_reg - 1'b1;
                end
            end
            if (adv) begin
                valid_a_reg <= in_fire;
                valid_b_reg <= valid_a_reg;
                valid_c_reg <= valid_b_reg;
            end
            if (m_valid_reg && m_ready) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    m_valid_reg <= pipe_out;
                end
            end else if (!m_valid_reg) begin
                m_valid_reg <= pipe_out;
            end else if (pipe_out) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            cur_a_reg       <= cur_in;
            col_a_reg       <= col_cnt_reg;
            row_ok_a_reg    <= row_ok;
            col_ok_a_reg    <= col_ok;
            meta_a_reg.row  <= wsf_pkg::COORD_OUT_BITS'(row_cnt_reg);
            meta_a_reg.col  <= wsf_pkg::COORD_OUT_BITS'(col_cnt_reg);
            meta_a_reg.last <= (row_cnt_reg == '0) && (col_cnt_reg == '0);
            meta_b_reg      <= meta_a_reg;
            meta_c_reg      <= meta_b_reg;
        end
    end

    // line buffers: read at the incoming column, shift down one row on write
    assign lb_we = adv & valid_a_reg;

    wsf_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (MAX_SIZE)
    ) u_row_below_one (
        .aclk  (aclk),
        .we    (lb_we),
        .waddr (col_a_reg),
        .wdata (cur_a_reg),
        .re    (adv),
        .raddr (col_cnt_reg),
        .rdata (rd_one)
    );

    wsf_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (MAX_SIZE)
    ) u_row_below_two (
        .aclk  (aclk),
        .we    (lb_we),
        .waddr (col_a_reg),
        .wdata (rd_one),
        .re    (adv),
        .raddr (col_cnt_reg),
        .rdata (rd_two)
    );

    // leftmost window column: current pixel and the two line-buffer reads
    always_comb begin
        win_col[0][0] = cur_a_reg;
        win_col[0][1] = rd_one;
        win_col[0][2] = rd_two;
    end

    // chain of window cells, each column handed right to left in pixel order
    for (genvar j = 0; j < WD; j++) begin : g_cell
        localparam logic [WD-1:0][wsf_pkg::DIV_SHIFT-1:0] COEF = wsf_pkg::tap_col_coef(j);

        always_comb begin
            cell_ctl[j].adv   = adv;
            cell_ctl[j].shift = adv & valid_a_reg;
            cell_ctl[j].clear = cfg_fire;
            for (int i = 0; i < WD; i++) begin
                cell_ctl[j].tap_en[i] = row_ok_a_reg[i] & col_ok_a_reg[j];
            end
        end

        if (j < WD - 1) begin : g_mid
            wsf_cell #(
                .COLOR_BITS (COLOR_BITS)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (cell_ctl[j]),
                .coef    (COEF),
                .col_in  (win_col[j]),
                .col_out (win_col[j+1]),
                .col_sum (col_sum[j])
            );
        end else begin : g_end
            wsf_cell #(
                .COLOR_BITS (COLOR_BITS)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (cell_ctl[j]),
                .coef    (COEF),
                .col_in  (win_col[j]),
                .col_out (),
                .col_sum (col_sum[j])
            );
        end
    end

    // final sum across the three column sums
    always_comb begin
        for (int k = 0; k < NC; k++) begin
            fsum[k] = '0;
            for (int j = 0; j < WD; j++) begin
                fsum[k] = fsum[k] + col_sum[j][k];
            end
        end
    end

    assign new_meta = meta_c_reg;

    // output register and skid payload
    always_ff @(posedge aclk) begin
        if (m_valid_reg && m_ready && skid_valid_reg) begin
            out_pix_reg  <= skid_pix_reg;
            out_meta_reg <= skid_meta_reg;
        end else if (pipe_out && (!m_valid_reg || m_ready)) begin
            out_pix_reg  <= fsum;
            out_meta_reg <= new_meta;
        end
        if (pipe_out && m_valid_reg && !m_ready) begin
            skid_pix_reg  <= fsum;
            skid_meta_reg <= new_meta;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = wsf_pkg::COLOR_PORT_BITS'(out_pix_reg[0]);
    assign m_green_out = wsf_pkg::COLOR_PORT_BITS'(out_pix_reg[1]);
    assign m_blue_out  = wsf_pkg::COLOR_PORT_BITS'(out_pix_reg[2]);
    assign m_out_row   = out_meta_reg.row;
    assign m_out_col   = out_meta_reg.col;
    assign m_frame_end = out_meta_reg.last;

    // skid only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register full while output register empty");

    // end of frame only on the top-left pixel
    a_frame_end_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> (m_out_row == '0 && m_out_col == '0))
        else $error("frame end marked away from pixel zero");

    // column counter steps down by one inside a row
    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !cfg_fire && col_cnt_reg != '0)
            |=> (col_cnt_reg == $past(col_cnt_reg) - 1'b1))
        else $error("column counter skipped a pixel");

    // position counters stay inside the image
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (EXT_BITS'(row_cnt_reg) < EXT_BITS'(size_reg))
            && (EXT_BITS'(col_cnt_reg) < EXT_BITS'(size_reg)))
        else $error("position counter outside the image");

endmodule

// File: rtl/wsf_ram.sv
// generic simple dual-port ram with registered read
module wsf_ram #(
    parameter int WIDTH = wsf_pkg::NUM_COLORS * wsf_pkg::DEFAULT_COLOR_BITS,
    parameter int DEPTH = wsf_pkg::DEFAULT_MAX_SIZE
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/wsf_cell.sv
// one window column cell: holds a pixel column, weights it and sums it
module wsf_cell #(
    parameter int COLOR_BITS = wsf_pkg::DEFAULT_COLOR_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  wsf_pkg::cell_ctl_t                    ctl,
    input  logic [wsf_pkg::WIN_DIM-1:0][wsf_pkg::DIV_SHIFT-1:0] coef,
    input  logic [wsf_pkg::WIN_DIM-1:0][wsf_pkg::NUM_COLORS-1:0][COLOR_BITS-1:0] col_in,
    output logic [wsf_pkg::WIN_DIM-1:0][wsf_pkg::NUM_COLORS-1:0][COLOR_BITS-1:0] col_out,
    output logic [wsf_pkg::NUM_COLORS-1:0][COLOR_BITS-1:0] col_sum
);

    localparam int PROD_BITS = COLOR_BITS + wsf_pkg::DIV_SHIFT;

    logic [wsf_pkg::WIN_DIM-1:0][wsf_pkg::NUM_COLORS-1:0][COLOR_BITS-1:0] hold_reg;
    logic [wsf_pkg::WIN_DIM-1:0][wsf_pkg::NUM_COLORS-1:0][PROD_BITS-1:0]  prod;
    logic [wsf_pkg::WIN_DIM-1:0][wsf_pkg::NUM_COLORS-1:0][COLOR_BITS-1:0] term;
    logic [wsf_pkg::WIN_DIM-1:0][wsf_pkg::NUM_COLORS-1:0][COLOR_BITS-1:0] term_reg;
    logic [wsf_pkg::NUM_COLORS-1:0][COLOR_BITS-1:0] sum;
    logic [wsf_pkg::NUM_COLORS-1:0][COLOR_BITS-1:0] col_sum_reg;

    // column handed on to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= '0;
        end else if (ctl.clear) begin
            hold_reg <= '0;
        end else if (ctl.shift) begin
            hold_reg <= col_in;
        end
    end

    // truncated weighted taps, one constant multiply per tap and color
    always_comb begin
        for (int i = 0; i < wsf_pkg::WIN_DIM; i++) begin
            for (int k = 0; k < wsf_pkg::NUM_COLORS; k++) begin
                prod[i][k] = PROD_BITS'(col_in[i][k]) * PROD_BITS'(coef[i]);
                term[i][k] = ctl.tap_en[i] ? prod[i][k][wsf_pkg::DIV_SHIFT +: COLOR_BITS]
                                           : '0;
            end
        end
    end

    // column sum, wraps at the color width
    always_comb begin
        for (int k = 0; k < wsf_pkg::NUM_COLORS; k++) begin
            sum[k] = '0;
            for (int i = 0; i < wsf_pkg::WIN_DIM; i++) begin
                sum[k] = sum[k] + term_reg[i][k];
            end
        end
    end

    // tap and sum stages
    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            term_reg    <= term;
            col_sum_reg <= sum;
        end
    end

    assign col_out = hold_reg;
    assign col_sum = col_sum_reg;

endmodule

// File: tb/weighted_3x3_stencil_filter_test.sv
// self-checking testbench for the weighted 3x3 stencil filter: directed table, then random frames
`timescale 1ns / 100ps

module weighted_3x3_stencil_filter_test;

    // color planes, index 0 red, 1 green, 2 blue
    typedef logic [0:2][wsf_pkg::COLOR_PORT_BITS-1:0] rgb_word_t;

    typedef struct packed {
        logic [wsf_pkg::COLOR_PORT_BITS-1:0] red;
        logic [wsf_pkg::COLOR_PORT_BITS-1:0] green;
        logic [wsf_pkg::COLOR_PORT_BITS-1:0] blue;
        logic [wsf_pkg::COORD_OUT_BITS-1:0]  row;
        logic [wsf_pkg::COORD_OUT_BITS-1:0]  col;
        logic                                frame_end;
    } filtered_pixel_t;

    typedef enum logic {PLAN_SIZE, PLAN_PIXEL} plan_kind_t;

    typedef struct packed {
        plan_kind_t                    kind;
        logic [wsf_pkg::CFG_BITS-1:0]  size_word;
        rgb_word_t                     px;
        logic                          typed;
        filtered_pixel_t               want;
    } plan_row_t;

    localparam int unsigned MODEL_MAX_SIZE    = 1024;
    localparam int unsigned POWER_ON_SIZE     = 64;
    localparam int unsigned DRAIN_CYCLES      = 12;
    localparam int unsigned LONG_HOLD_CYCLES  = 300;
    localparam int unsigned ITEMS_PER_MODE    = 500;
    localparam int unsigned WATCHDOG_CYCLES   = 400000;
    localparam int unsigned SRC_IDLE_PCT [3]  = '{11, 45, 0};
    localparam int unsigned SINK_IDLE_PCT [3] = '{45, 11, 0};

    // weights in hundredths, [window row][window column]
    localparam int unsigned TAP_HUNDREDTHS [3][3] = '{
        '{60, 3, 0},
        '{3, 30, 3},
        '{0, 3, 10}
    };

    localparam rgb_word_t       ALL_ONES = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    localparam filtered_pixel_t NO_WANT  = '0;

    // directed stimulus: size words and pixels, typed results only where obvious
    localparam plan_row_t DIRECTED_PLAN [27] = '{
        // power-on size 64: first word is the bottom-right corner, only its own tap
        '{PLAN_PIXEL, 11'd0, ALL_ONES, 1'b1,
          '{16'd39321, 16'd39321, 16'd39321, 10'd63, 10'd63, 1'b0}},
        '{PLAN_PIXEL, 11'd0, '{16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, '{16'h0001, 16'h8000, 16'h7FFF}, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, '{16'hAAAA, 16'h5555, 16'hFFFF}, 1'b0, NO_WANT},
        // size zero taken as one: every word is a whole frame
        '{PLAN_SIZE, 11'd0, '0, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, '{16'hFFFF, 16'h0000, 16'hFFFF}, 1'b1,
          '{16'd39321, 16'd0, 16'd39321, 10'd0, 10'd0, 1'b1}},
        '{PLAN_PIXEL, 11'd0, '{16'd100, 16'd200, 16'd1}, 1'b1,
          '{16'd60, 16'd120, 16'd0, 10'd0, 10'd0, 1'b1}},
        // 3x3 frame of full scale, sum wraps at the top-left corner
        '{PLAN_SIZE, 11'd3, '0, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, ALL_ONES, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, ALL_ONES, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, ALL_ONES, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, ALL_ONES, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, ALL_ONES, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, ALL_ONES, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, ALL_ONES, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, ALL_ONES, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, ALL_ONES, 1'b0, NO_WANT},
        // next frame starts over at the bottom-right corner
        '{PLAN_PIXEL, 11'd0, '{16'h1234, 16'hFEDC, 16'h00FF}, 1'b0, NO_WANT},
        // oversize word clamps to the largest image, written mid-frame
        '{PLAN_SIZE, 11'h7FF, '0, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, ALL_ONES, 1'b1,
          '{16'd39321, 16'd39321, 16'd39321, 10'd1023, 10'd1023, 1'b0}},
        '{PLAN_PIXEL, 11'd0, '{16'h0000, 16'hFFFF, 16'h0000}, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, '{16'h8000, 16'h0001, 16'h4000}, 1'b0, NO_WANT},
        // 2x2 frame, restart from the large size mid-row
        '{PLAN_SIZE, 11'd2, '0, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, '{16'h0100, 16'h0200, 16'h0400}, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, '{16'h0800, 16'h1000, 16'h2000}, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, '{16'hFFFF, 16'hFFFE, 16'hFFFD}, 1'b0, NO_WANT},
        '{PLAN_PIXEL, 11'd0, '{16'h0003, 16'h0002, 16'h0001}, 1'b0, NO_WANT}
    };

    logic                                aclk           = 1'b0;
    logic                                aresetn        = 1'b0;
    logic                                cfg_valid      = 1'b0;
    logic                                cfg_ready;
    logic [wsf_pkg::CFG_BITS-1:0]        cfg_image_size = '0;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic [wsf_pkg::COLOR_PORT_BITS-1:0] s_red_in       = '0;
    logic [wsf_pkg::COLOR_PORT_BITS-1:0] s_green_in     = '0;
    logic [wsf_pkg::COLOR_PORT_BITS-1:0] s_blue_in      = '0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic [wsf_pkg::COLOR_PORT_BITS-1:0] m_red_out;
    logic [wsf_pkg::COLOR_PORT_BITS-1:0] m_green_out;
    logic [wsf_pkg::COLOR_PORT_BITS-1:0] m_blue_out;
    logic [wsf_pkg::COORD_OUT_BITS-1:0]  m_out_row;
    logic [wsf_pkg::COORD_OUT_BITS-1:0]  m_out_col;
    logic                                m_frame_end;

    // filter state as the predictor sees it
    int unsigned frame_size;
    int unsigned pos_row;
    int unsigned pos_col;
    rgb_word_t   line_one [MODEL_MAX_SIZE];
    rgb_word_t   line_two [MODEL_MAX_SIZE];
    rgb_word_t   right_pair [2];
    rgb_word_t   mid_pair [2];
    rgb_word_t   low_pair [2];

    filtered_pixel_t pending_pixels [$];
    int unsigned     mismatches    = 0;
    int unsigned     src_idle_pct  = 0;
    int unsigned     sink_idle_pct = 0;
    int unsigned     hold_left     = 0;
    int unsigned     cycle_count   = 0;
    bit              hold_arm      = 1'b0;
    bit              hold_taken    = 1'b0;

    weighted_3x3_stencil_filter u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_image_size (cfg_image_size),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red_in       (s_red_in),
        .s_green_in     (s_green_in),
        .s_blue_in      (s_blue_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red_out      (m_red_out),
        .m_green_out    (m_green_out),
        .m_blue_out     (m_blue_out),
        .m_out_row      (m_out_row),
        .m_out_col      (m_out_col),
        .m_frame_end    (m_frame_end)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // new size word: clamp, counters to the bottom-right corner, clear the window
    function automatic void restart_frame_model(input logic [wsf_pkg::CFG_BITS-1:0] size_word);
        if (size_word == '0)
            frame_size = 1;
        else if (size_word > MODEL_MAX_SIZE)
            frame_size = MODEL_MAX_SIZE;
        else
            frame_size = size_word;
        pos_row    = frame_size - 1;
        pos_col    = frame_size - 1;
        right_pair = '{'0, '0};
        mid_pair   = '{'0, '0};
        low_pair   = '{'0, '0};
    endfunction

    // filtered word for the next pixel; moves the line buffers and counters on
    function automatic filtered_pixel_t filter_next_pixel(input rgb_word_t px);
        filtered_pixel_t res;
        rgb_word_t       win [3][3];
        rgb_word_t       sums;
        int unsigned     r;
        int unsigned     c;
        int unsigned     acc;
        r = (pos_row >= frame_size) ? frame_size - 1 : pos_row;
        c = (pos_col >= frame_size) ? frame_size - 1 : pos_col;
        win[0][0] = px;          win[0][1] = right_pair[0]; win[0][2] = right_pair[1];
        win[1][0] = line_one[c]; win[1][1] = mid_pair[0];   win[1][2] = mid_pair[1];
        win[2][0] = line_two[c]; win[2][1] = low_pair[0];   win[2][2] = low_pair[1];
        // taps outside the image are skipped, each tap truncated on its own
        for (int k = 0; k < 3; k++) begin
            acc = 0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (r + i < frame_size && c + j < frame_size)
                        acc += (win[i][j][k] * TAP_HUNDREDTHS[i][j]) / 100;
                end
            end
            sums[k] = 16'(acc);
        end
        res.red       = sums[0];
        res.green     = sums[1];
        res.blue      = sums[2];
        res.row       = 10'(r);
        res.col       = 10'(c);
        res.frame_end = (r == 0) && (c == 0);
        // rows move down one at this column
        line_two[c]   = win[1][0];
        line_one[c]   = px;
        right_pair[1] = right_pair[0]; right_pair[0] = px;
        mid_pair[1]   = mid_pair[0];   mid_pair[0]   = win[1][0];
        low_pair[1]   = low_pair[0];   low_pair[0]   = win[2][0];
        // reverse raster step
        if (c == 0) begin
            pos_col = frame_size - 1;
            pos_row = (r == 0) ? frame_size - 1 : r - 1;
        end else begin
            pos_col = c - 1;
            pos_row = r;
        end
        return res;
    endfunction

    // offer one pixel word; called and returning at a falling edge
    task automatic offer_pixel(input rgb_word_t px, input logic typed,
                               input filtered_pixel_t typed_want);
        filtered_pixel_t want;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid    <= 1'b1;
        s_red_in   <= px[0];
        s_green_in <= px[1];
        s_blue_in  <= px[2];
        do @(posedge aclk); while (s_ready !== 1'b1);
        want = filter_next_pixel(px);
        if (typed)
            want = typed_want;
        pending_pixels.push_back(want);
        @(negedge aclk);
    endtask

    // stop offering, let every expected word arrive, then let the pipe empty
    task automatic settle_block();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // size register write, only while the block is idle
    task automatic write_image_size(input logic [wsf_pkg::CFG_BITS-1:0] size_word);
        cfg_valid      <= 1'b1;
        cfg_image_size <= size_word;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        restart_frame_model(size_word);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // receiver side: random stalls, plus one long hold-off when armed
    always @(negedge aclk) begin
        if (hold_arm && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic note_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    // result check against the oldest expected word
    always @(posedge aclk) begin
        filtered_pixel_t got;
        filtered_pixel_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            got = '{m_red_out, m_green_out, m_blue_out, m_out_row, m_out_col, m_frame_end};
            if (pending_pixels.size() == 0) begin
                $display("%0t: result word with nothing expected, expected none, actual %h",
                         $time, got);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (got.red !== want.red)             note_mismatch("red", want.red, got.red);
                if (got.green !== want.green)         note_mismatch("green", want.green, got.green);
                if (got.blue !== want.blue)           note_mismatch("blue", want.blue, got.blue);
                if (got.row !== want.row)             note_mismatch("row", want.row, got.row);
                if (got.col !== want.col)             note_mismatch("col", want.col, got.col);
                if (got.frame_end !== want.frame_end)
                    note_mismatch("frame_end", want.frame_end, got.frame_end);
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < WATCHDOG_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // stimulus
    initial begin
        rgb_word_t                    px;
        logic [wsf_pkg::CFG_BITS-1:0] size_word;
        int unsigned                  budget;
        int unsigned                  count;
        int unsigned                  roll;
        restart_frame_model(wsf_pkg::CFG_BITS'(POWER_ON_SIZE));
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (DIRECTED_PLAN[i]) begin
            if (DIRECTED_PLAN[i].kind == PLAN_SIZE) begin
                settle_block();
                write_image_size(DIRECTED_PLAN[i].size_word);
            end else begin
                offer_pixel(DIRECTED_PLAN[i].px, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
            end
        end

        // random frames under three idling patterns
        for (int mode = 0; mode < 3; mode++) begin
            src_idle_pct  = SRC_IDLE_PCT[mode];
            sink_idle_pct = SINK_IDLE_PCT[mode];
            budget        = ITEMS_PER_MODE;
            while (budget > 0) begin
                // mostly small images, now and then the edges of the size range
                roll = $urandom_range(99);
                if (roll < 5)
                    size_word = '0;
                else if (roll < 10)
                    size_word = 11'd1;
                else if (roll < 15)
                    size_word = 11'd2;
                else if (roll < 18)
                    size_word = 11'h7FF;
                else if (roll < 20)
                    size_word = 11'd1024;
                else if (roll < 24)
                    size_word = 11'($urandom_range(2047));
                else if (roll < 70)
                    size_word = 11'($urandom_range(8, 3));
                else
                    size_word = 11'($urandom_range(24, 9));
                settle_block();
                write_image_size(size_word);

                // whole frames with a partial tail, or a slice of a big frame
                if (frame_size * frame_size <= 150)
                    count = frame_size * frame_size * $urandom_range(3, 1)
                            + $urandom_range(frame_size);
                else
                    count = $urandom_range(150, 20);
                // long receiver hold-off while the sender keeps pushing
                if (mode == 2 && !hold_arm) begin
                    hold_arm = 1'b1;
                    if (count < 80)
                        count = 80;
                end
                if (count > budget)
                    count = budget;
                budget -= count;

                repeat (count) begin
                    for (int k = 0; k < 3; k++) begin
                        case ($urandom_range(9))
                            0:       px[k] = '0;
                            1:       px[k] = 16'hFFFF;
                            2:       px[k] = 16'(1) << $urandom_range(15);
                            default: px[k] = 16'($urandom_range(16'hFFFF));
                        endcase
                    end
                    offer_pixel(px, 1'b0, NO_WANT);
                end
            end
        end

        settle_block();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
